// ===== sv/cfpr_pkg.sv =====
`default_nettype none

package cfpr_pkg;

	// Frame bytes and limits
	localparam logic [7:0] SYNC_FIRST      = 8'hAA;
	localparam logic [7:0] SYNC_SECOND     = 8'hAF;
	localparam logic [7:0] FUNC_BOUND      = 8'hF1;
	localparam logic [7:0] FUNC_READ       = 8'h02;
	localparam logic [7:0] READ_SELECT     = 8'h01;
	localparam logic [7:0] FUNC_GROUP_LOW  = 8'h10;
	localparam logic [7:0] FUNC_GROUP_HIGH = 8'h15;
	localparam logic [7:0] LIMIT_RESET     = 8'd50;

	// Parser phase
	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_SYNC1 = 3'd1,
		PH_SYNC2 = 3'd2,
		PH_FUNC  = 3'd3,
		PH_DATA  = 3'd4,
		PH_SUM   = 3'd5
	} phase_t;

	// Result kind
	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_PAYLOAD = 2'd1,
		EV_GOOD    = 2'd2,
		EV_SUM_ERR = 2'd3
	} event_t;

	// One result
	typedef struct packed {
		event_t     event_res;
		logic [7:0] function_code;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
		logic [7:0] frame_sum;
		logic [2:0] group_write;
		logic       read_request;
	} result_t;

endpackage

`default_nettype wire

// ===== sv/command_frame_receive_parser_top.sv =====
// A result appears on the master side in the cycle after its byte is accepted.
// Throughput: one byte per cycle while the master side takes results; every byte yields exactly one result.
// The result register frees itself when the master side takes it, so a byte can be
// accepted in the same cycle that the previous result leaves.
// Reset (arst_n low, asynchronous): parser idle, all frame state zero, length limit 50,
// no result pending.
`default_nettype none

module command_frame_receive_parser_top
	import cfpr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // [7:0] function_code, [15:8] payload_byte,
	                                    // [23:16] payload_index, [31:24] frame_sum,
	                                    // [34:32] group_write, [35] read_request, rest zero
	output logic [1:0]       m_tuser,   // [1:0] event_res
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata  // [7:0] length_limit
);

	logic    s_accept;
	result_t result;
	result_t result_q;
	logic    valid_q;

	// Take a request whenever the result register is empty or draining
	assign s_tready = !valid_q || m_tready;
	assign s_accept = s_tvalid && s_tready;

	cfpr_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (s_accept),
		.rx_byte   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.result    (result)
	);

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_tready) begin
			valid_q <= s_tvalid;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (s_accept) begin
			result_q <= result;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tuser  = result_q.event_res;
	assign m_tdata  = {4'b0000, result_q.read_request, result_q.group_write,
		result_q.frame_sum, result_q.payload_index, result_q.payload_byte,
		result_q.function_code};

	// An accepted byte always yields a result next cycle
	assert property (@(posedge clk) disable iff (!arst_n) s_accept |=> m_tvalid)
		else $error("accepted byte gave no result");

	// Group write and read request only on a good frame
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[35:32] != 4'b0000)) |-> (m_tuser == EV_GOOD))
		else $error("classification outside good frame");

	// A read request always carries the read function
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[35]) |-> (m_tdata[7:0] == FUNC_READ && m_tdata[34:32] == 3'd0))
		else $error("read request with wrong function");

	// An empty result carries all-zero fields
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == EV_NONE) |-> (m_tdata == 40'd0))
		else $error("nonzero fields on empty result");

endmodule

`default_nettype wire

// ===== sv/cfpr_core.sv =====
`default_nettype none

module cfpr_core
	import cfpr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] rx_byte,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,
	output result_t         result
);

	phase_t     phase_q, phase_d;
	logic [7:0] left_q, left_d;
	logic [7:0] taken_q, taken_d;
	logic [7:0] sum_q, sum_d;
	logic [7:0] func_q, func_d;
	logic [7:0] first_q, first_d;
	logic [7:0] limit_q;
	logic [7:0] sum_next;
	logic [7:0] group_off;

	assign sum_next  = sum_q + rx_byte;
	assign group_off = func_q - FUNC_GROUP_LOW + 8'd1;

	// Next state and result for the byte on the input
	always_comb begin
		phase_d = PH_IDLE;
		left_d  = left_q;
		taken_d = taken_q;
		sum_d   = sum_q;
		func_d  = func_q;
		first_d = first_q;
		result  = '0;
		if (phase_q == PH_IDLE && rx_byte == SYNC_FIRST) begin
			phase_d = PH_SYNC1;
			sum_d   = rx_byte;
		end else if (phase_q == PH_SYNC1 && rx_byte == SYNC_SECOND) begin
			phase_d = PH_SYNC2;
			sum_d   = sum_next;
		end else if (phase_q == PH_SYNC2 && rx_byte < FUNC_BOUND) begin
			phase_d = PH_FUNC;
			func_d  = rx_byte;
			sum_d   = sum_next;
		end else if (phase_q == PH_FUNC && rx_byte < limit_q) begin
			phase_d = PH_DATA;
			left_d  = rx_byte;
			taken_d = 8'd0;
			sum_d   = sum_next;
		end else if (phase_q == PH_DATA && left_q != 8'd0) begin
			if (taken_q == 8'd0) begin
				first_d = rx_byte;
			end
			result.event_res     = EV_PAYLOAD;
			result.function_code = func_q;
			result.payload_byte  = rx_byte;
			result.payload_index = taken_q;
			taken_d = taken_q + 8'd1;
			left_d  = left_q - 8'd1;
			sum_d   = sum_next;
			phase_d = (left_q == 8'd1) ? PH_SUM : PH_DATA;
		end else if (phase_q == PH_SUM) begin
			result.function_code = func_q;
			result.frame_sum     = sum_q;
			if (rx_byte == sum_q) begin
				result.event_res = EV_GOOD;
				if (func_q inside {[FUNC_GROUP_LOW:FUNC_GROUP_HIGH]}) begin
					result.group_write = group_off[2:0];
				end
				result.read_request = (func_q == FUNC_READ) && (first_q == READ_SELECT);
			end else begin
				result.event_res = EV_SUM_ERR;
			end
		end
	end

	// Hold parser state, advance on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			left_q  <= 8'd0;
			taken_q <= 8'd0;
			sum_q   <= 8'd0;
			func_q  <= 8'd0;
			first_q <= 8'd0;
		end else if (step) begin
			phase_q <= phase_d;
			left_q  <= left_d;
			taken_q <= taken_d;
			sum_q   <= sum_d;
			func_q  <= func_d;
			first_q <= first_d;
		end
	end

	// Length limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

endmodule

`default_nettype wire
